// ===== rtl/core/frd_pkg.sv =====
`default_nettype none
package frd_pkg;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 9;
	localparam int CAP_CNT = 7;
	localparam int CAP_FIRST = 2;
	localparam int EVENT_W = 3;
	localparam int STATUS_W = 2;
	localparam int ACCEL_W = 16;
	localparam int OUT_DATA_W = 80;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'hA5;
	localparam logic [BYTE_W-1:0] TAIL_BYTE  = 8'h5A;

	localparam logic [BYTE_W-1:0] CMD_SHUTDOWN_A = 8'd4;
	localparam logic [BYTE_W-1:0] CMD_SHUTDOWN_B = 8'd8;
	localparam logic [BYTE_W-1:0] CMD_LOW_VOLT  = 8'd5;
	localparam logic [BYTE_W-1:0] CMD_TIME_SYNC = 8'd10;
	localparam logic [BYTE_W-1:0] CMD_ACCEL     = 8'd19;

	localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
	localparam logic [EVENT_W-1:0] EV_SHUTDOWN  = 3'd1;
	localparam logic [EVENT_W-1:0] EV_LOW_VOLT  = 3'd2;
	localparam logic [EVENT_W-1:0] EV_TIME_SYNC = 3'd3;
	localparam logic [EVENT_W-1:0] EV_ACCEL     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_TAIL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd2;

	localparam logic REG_PENDING_CMD   = 1'b0;
	localparam logic REG_PENDING_VALID = 1'b1;

	typedef struct packed {
		logic               ack_match;
		logic [EVENT_W-1:0] event_code;
		logic               low_volt_set;
		logic               time_sync_set;
	} frd_decode_t;

endpackage
`default_nettype wire

// ===== rtl/core/frd_decode.sv =====
`default_nettype none
module frd_decode (
	input  wire logic                        frame_ok,
	input  wire logic [frd_pkg::BYTE_W-1:0] command_code,
	input  wire logic [frd_pkg::BYTE_W-1:0] result_code,
	input  wire logic [frd_pkg::BYTE_W-1:0] pending_command,
	input  wire logic                        pending_valid,
	output frd_pkg::frd_decode_t             dec
);
	import frd_pkg::*;

	logic [BYTE_W:0] pend_inc;
	logic [BYTE_W:0] cmd_inc;
	logic            res_zero;

	assign pend_inc = {1'b0, pending_command} + {{BYTE_W{1'b0}}, 1'b1};
	assign cmd_inc  = {1'b0, command_code} + {{BYTE_W{1'b0}}, 1'b1};
	assign res_zero = (result_code == '0);

	always_comb begin
		dec = '0;
		if (frame_ok) begin
			dec.ack_match = pending_valid && res_zero &&
				(pend_inc[BYTE_W:1] == cmd_inc[BYTE_W:1]);
			if (command_code == CMD_SHUTDOWN_A || command_code == CMD_SHUTDOWN_B) begin
				dec.event_code = EV_SHUTDOWN;
			end else if (command_code == CMD_LOW_VOLT) begin
				dec.event_code   = EV_LOW_VOLT;
				dec.low_volt_set = 1'b1;
			end else if (command_code == CMD_TIME_SYNC) begin
				if (res_zero) begin
					dec.event_code    = EV_TIME_SYNC;
					dec.time_sync_set = 1'b1;
				end
			end else if (command_code == CMD_ACCEL) begin
				dec.event_code = EV_ACCEL;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/frame_receive_deframer_core.sv =====
// Path from an input byte transfer to its frame result on the master side: the input
// register, then the result register.
// Throughput: one byte per cycle; input stalls only while a finished result is held
// by a low m_tready and the byte in the input register ends a frame.
// Reset (arst_n low, asynchronous) clears the parser state, capture bytes, sticky flags,
// configuration registers and both valid flags.
`default_nettype none
module frame_receive_deframer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// rx_byte [7:0]
	input  wire logic [frd_pkg::BYTE_W-1:0]         s_tdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// command_code [7:0], result_code [15:8], body_length [23:16], ack_match [24],
	// event_code [27:25], accel_x [43:28], accel_y [59:44], accel_z [75:60],
	// low_voltage_latched [76], time_sync_latched [77], zero [79:78]
	output logic [frd_pkg::OUT_DATA_W-1:0]          m_tdata,
	// frame_status [1:0]
	output logic [frd_pkg::STATUS_W-1:0]            m_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [frd_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [frd_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [frd_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                     pready
);
	import frd_pkg::*;

	logic [BYTE_W-1:0] pend_cmd_q;
	logic              pend_valid_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] chk_q;
	logic [BYTE_W-1:0] cap_q [CAP_CNT];
	logic              lv_q;
	logic              ts_q;

	logic [BYTE_W-1:0] cap_next [CAP_CNT];
	logic [POS_W-1:0]  len_plus2;
	logic              hunting;
	logic              is_len;
	logic              in_body;
	logic              is_chk;
	logic              is_tail;
	logic              out_free;
	logic              adv;
	logic              step;
	logic [STATUS_W-1:0] status;
	logic              frame_ok;
	logic              lv_next;
	logic              ts_next;
	frd_decode_t       dec;
	logic [OUT_DATA_W-1:0] out_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cmd_q   <= '0;
			pend_valid_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_PENDING_CMD:   pend_cmd_q   <= pwdata[BYTE_W-1:0];
				REG_PENDING_VALID: pend_valid_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[2])
				REG_PENDING_CMD:   prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, pend_cmd_q};
				REG_PENDING_VALID: prdata = {{(APB_DATA_W-1){1'b0}}, pend_valid_q};
				default:           prdata = '0;
			endcase
		end
	end

	assign hunting   = (pos_q == '0);
	assign is_len    = !hunting && (len_q == '0);
	assign len_plus2 = {1'b0, len_q} + POS_W'(CAP_FIRST);
	assign in_body   = pos_q < len_plus2;
	assign is_chk    = pos_q == len_plus2;
	assign is_tail   = valid_s1 && !hunting && !is_len && !in_body && !is_chk;

	assign out_free = !m_tvalid || m_tready;
	assign adv      = !is_tail || out_free;
	assign step     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		for (int i = 0; i < CAP_CNT; i++) begin
			cap_next[i] = cap_q[i];
			if (!hunting && !is_len && pos_q == POS_W'(i + CAP_FIRST)) begin
				cap_next[i] = byte_s1;
			end
		end
	end

	always_comb begin
		if (byte_s1 != TAIL_BYTE) begin
			status = ST_BAD_TAIL;
		end else if (chk_q != xor_q) begin
			status = ST_BAD_SUM;
		end else begin
			status = ST_OK;
		end
	end

	assign frame_ok = (status == ST_OK);

	frd_decode u_decode (
		.frame_ok        (frame_ok),
		.command_code    (cap_next[0]),
		.result_code     (cap_next[1]),
		.pending_command (pend_cmd_q),
		.pending_valid   (pend_valid_q),
		.dec             (dec)
	);

	assign lv_next = lv_q | dec.low_volt_set;
	assign ts_next = ts_q | dec.time_sync_set;

	always_comb begin
		out_data = '0;
		out_data[23:16] = len_q;
		out_data[76]    = lv_next;
		out_data[77]    = ts_next;
		if (frame_ok) begin
			out_data[7:0]   = cap_next[0];
			out_data[15:8]  = cap_next[1];
			out_data[24]    = dec.ack_match;
			out_data[27:25] = dec.event_code;
			out_data[43:28] = {cap_next[1], cap_next[2]};
			out_data[59:44] = {cap_next[3], cap_next[4]};
			out_data[75:60] = {cap_next[5], cap_next[6]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			xor_q <= '0;
			chk_q <= '0;
			lv_q  <= 1'b0;
			ts_q  <= 1'b0;
			for (int i = 0; i < CAP_CNT; i++) begin
				cap_q[i] <= '0;
			end
		end else if (step) begin
			if (hunting) begin
				if (byte_s1 == START_BYTE) begin
					pos_q <= POS_W'(1);
					len_q <= '0;
				end
			end else if (is_len) begin
				len_q <= byte_s1;
				xor_q <= START_BYTE ^ byte_s1;
				pos_q <= POS_W'(CAP_FIRST);
			end else begin
				for (int i = 0; i < CAP_CNT; i++) begin
					cap_q[i] <= cap_next[i];
				end
				if (in_body) begin
					pos_q <= pos_q + POS_W'(1);
					xor_q <= xor_q ^ byte_s1;
				end else if (is_chk) begin
					pos_q <= pos_q + POS_W'(1);
					chk_q <= byte_s1;
				end else begin
					pos_q <= '0;
					len_q <= '0;
					lv_q  <= lv_next;
					ts_q  <= ts_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (step && is_tail) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_tail) begin
			m_tdata <= out_data;
			m_tuser <= status;
		end
	end

	a_len_clear_while_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> len_q == '0)
		else $error("length held while hunting for start");

	a_reject_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[15:0] == '0 && m_tdata[75:24] == '0)
		else $error("rejected frame carries decoded fields");

	a_accel_x_high_is_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK |-> m_tdata[43:36] == m_tdata[15:8])
		else $error("accel_x high byte differs from result byte");

	a_sticky_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(lv_q) && !$fell(ts_q))
		else $error("sticky flag cleared");

endmodule
`default_nettype wire
